// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ghn_pkg.sv
// ghn_pkg.sv: constants and item codes for the gray histogram normalizer.
// No dependencies.
`default_nettype none

package ghn_pkg;

    // Default sizing of the histogram.
    localparam int NUM_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths.
    localparam int MODE_BITS   = 2;
    localparam int PIXEL_BITS  = 8;
    localparam int SCALE_BITS  = 16;
    localparam int HEIGHT_BITS = 16;
    localparam int OUT_CNT_BITS = 24;

    // Reset value of the bar scale register.
    localparam logic [SCALE_BITS-1:0] BAR_SCALE_RESET = 16'd400;

    // Item kinds carried on the input tuser.
    localparam logic [MODE_BITS-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

endpackage

`default_nettype wire

// File: rtl/gray_histogram_normalizer.sv
// gray_histogram_normalizer.sv: histogram memory, read-modify-write pipeline and
// an iterative divider for the normalized bar height. Depends on ghn_pkg and
// assert_macros.svh.
//
//  channel   dir  fields (lowest bit first)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tuser: mode[1:0]; tdata: pixel_value[7:0], bin_index[15:8]
//  m_axis    out  tdata: bin_count[23:0], bar_height[39:24], max_count[63:40]
//  cfg       in   i_cfg_we, i_cfg_wdata: bar_scale[15:0]
//
// Add items stream at one per cycle while no read or clear is in progress; back-to-back
// hits on one bin are forwarded. A read item holds s_axis off after its transaction
// through stage one, the multiply, HEIGHT_BITS divider steps (skipped when the peak is
// zero) and the output load. Reset release starts a clearing pass over all NUM_BINS bins;
// a clear item holds s_axis off through its stage one and a further clearing pass.
// A result waiting on m_axis stalls only the next read, which then waits in ST_DONE.
`default_nettype none

`include "assert_macros.svh"

module gray_histogram_normalizer #(
    parameter int NUM_BINS   = ghn_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = ghn_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,   // bar_scale[15:0]
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // pixel_value[7:0], bin_index[15:8]
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // bin_count[23:0], bar_height[39:24],
                                            // max_count[63:40]
);

    localparam int IDX_W   = $clog2(NUM_BINS);
    localparam int H_W     = ghn_pkg::HEIGHT_BITS;
    localparam int PROD_W  = COUNT_BITS + ghn_pkg::SCALE_BITS;
    localparam int DCNT_W  = $clog2(H_W);
    localparam logic [IDX_W-1:0]      LAST_BIN    = IDX_W'(NUM_BINS - 1);
    localparam logic [DCNT_W-1:0]     LAST_STEP   = DCNT_W'(H_W - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;

    // Input field decode.
    logic [ghn_pkg::PIXEL_BITS-1:0] in_pixel;
    logic [ghn_pkg::PIXEL_BITS-1:0] in_bin;
    logic                           s_accept;
    logic [IDX_W-1:0]               rd_addr;
    logic                           rd_in_range;

    // Stage one: item whose memory read is returning.
    logic                           r_s1_valid;
    logic [ghn_pkg::MODE_BITS-1:0]  r_s1_mode;
    logic [IDX_W-1:0]               r_s1_addr;
    logic                           r_s1_in_range;

    // Memory and forwarding.
    logic [COUNT_BITS-1:0] r_bin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_fwd_hit;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  pix_wr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // Control and arithmetic registers.
    logic [IDX_W-1:0]                r_clr_addr;
    logic [COUNT_BITS-1:0]           r_peak;
    logic [ghn_pkg::SCALE_BITS-1:0]  r_bar_scale;
    logic [COUNT_BITS-1:0]           r_cnt;
    logic [COUNT_BITS-1:0]           r_rem;
    logic [H_W-1:0]                  r_dvd_lo;
    logic [H_W-1:0]                  r_quot;
    logic [DCNT_W-1:0]               r_div_cnt;
    logic [PROD_W-1:0]               product;
    logic [COUNT_BITS:0]             rem_shift;
    logic [COUNT_BITS:0]             rem_diff;
    logic                            rem_ge;

    // Output register.
    logic        r_out_valid;
    logic [63:0] r_out_data;

    // Handshake and field decode.
    assign in_pixel      = s_axis_tdata[7:0];
    assign in_bin        = s_axis_tdata[15:8];
    assign s_axis_tready = (r_state == ST_RUN) &&
                           !(r_s1_valid && ((r_s1_mode == ghn_pkg::MODE_READ) ||
                                            (r_s1_mode == ghn_pkg::MODE_CLEAR)));
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Read address: the pixel for add items, the bin for everything else.
    always_comb begin
        if (s_axis_tuser == ghn_pkg::MODE_ADD) begin
            rd_addr     = IDX_W'(in_pixel);
            rd_in_range = (32'(in_pixel) < 32'(NUM_BINS));
        end else begin
            rd_addr     = IDX_W'(in_bin);
            rd_in_range = (32'(in_bin) < 32'(NUM_BINS));
        end
    end

    // Count of the stage-one bin, with the saturating increment.
    assign cur_count = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign n_count   = (cur_count == COUNT_LIMIT) ? cur_count : cur_count + 1'b1;
    assign pix_wr    = r_s1_valid && (r_s1_mode == ghn_pkg::MODE_ADD) && r_s1_in_range;

    // Single write port: the clearing pass or the add write-back.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = pix_wr;
            wr_addr = r_s1_addr;
            wr_data = n_count;
        end
    end

    // Histogram memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bin_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_bin_mem[rd_addr];
    end

    // Forwarding of a write-back that collides with the read issued at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= s_accept && pix_wr && (rd_addr == r_s1_addr);
        end
        r_fwd_data <= n_count;
    end

    // Stage-one item registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_accept;
        end
        r_s1_mode     <= s_axis_tuser;
        r_s1_addr     <= rd_addr;
        r_s1_in_range <= rd_in_range;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_scale <= ghn_pkg::BAR_SCALE_RESET;
        end else if (i_cfg_we) begin
            r_bar_scale <= i_cfg_wdata;
        end
    end

    // Divider datapath: one restoring step per cycle.
    assign product   = PROD_W'(r_cnt) * PROD_W'(r_bar_scale);
    assign rem_shift = {r_rem, r_dvd_lo[H_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_peak};
    assign rem_ge    = (rem_shift >= {1'b0, r_peak});

    // Sequencer: clearing pass, stage-one actions, multiply, divide and output load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_BIN) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (pix_wr && (n_count > r_peak)) begin
                        r_peak <= n_count;
                    end
                    if (r_s1_valid && (r_s1_mode == ghn_pkg::MODE_READ)) begin
                        r_cnt   <= r_s1_in_range ? cur_count : '0;
                        r_state <= ST_MUL;
                    end else if (r_s1_valid && (r_s1_mode == ghn_pkg::MODE_CLEAR)) begin
                        r_peak     <= '0;
                        r_clr_addr <= '0;
                        r_state    <= ST_CLEAR;
                    end
                end
                ST_MUL: begin
                    // The quotient fits HEIGHT_BITS because a count never exceeds the peak.
                    r_rem     <= product[PROD_W-1:H_W];
                    r_dvd_lo  <= product[H_W-1:0];
                    r_div_cnt <= '0;
                    if (r_peak == '0) begin
                        r_quot  <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem     <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
                    r_dvd_lo  <= {r_dvd_lo[H_W-2:0], 1'b0};
                    r_quot    <= {r_quot[H_W-2:0], rem_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid) begin
                        r_out_data  <= {ghn_pkg::OUT_CNT_BITS'(r_peak), r_quot,
                                        ghn_pkg::OUT_CNT_BITS'(r_cnt)};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The peak never falls below a count just written back.
    `ASSERT_CLKD(a_peak, i_clk, i_rst_n, pix_wr |=> r_peak >= $past(n_count), "peak too low")
    // A bin read for normalization never exceeds the peak.
    `ASSERT_CLKD(a_cnt, i_clk, i_rst_n, r_state == ST_MUL |-> r_cnt <= r_peak, "count above peak")
    // The bar height never exceeds the scale.
    `ASSERT_CLKD(a_hgt, i_clk, i_rst_n, r_state == ST_DONE |-> r_quot <= r_bar_scale, "bad height")
    // The peak stays zero during a clearing pass.
    `ASSERT_CLKD(a_clr, i_clk, i_rst_n, r_state == ST_CLEAR |-> r_peak == '0, "peak set in clear")

endmodule

`default_nettype wire

// File: test/tb.sv
// tb.sv: self-checking testbench for the gray histogram normalizer.
// Depends on ghn_pkg and gray_histogram_normalizer; it keeps its own histogram
// model and checks every read transaction, field by field, against it.
module tb;

    // Mode 3 has no meaning; the block must drop such items.
    localparam logic [ghn_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    // This covers the clearing pass over all NUM_BINS bins with margin.
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS   = 1600;

    typedef enum int {PACE_STEADY, PACE_BURSTY} t_pace;

    typedef struct {
        logic [ghn_pkg::OUT_CNT_BITS-1:0] bin_count;
        logic [ghn_pkg::HEIGHT_BITS-1:0]  bar_height;
        logic [ghn_pkg::OUT_CNT_BITS-1:0] max_count;
    } t_read_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // pixel_value[7:0], bin_index[15:8]
    logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // bin_count[23:0], bar_height[39:24], max_count[63:40]

    // Pacing of both sides and the request for a long receiver hold-off.
    t_pace tx_pace = PACE_STEADY;
    t_pace rx_pace = PACE_STEADY;
    int    rx_hold_ticket = 0;

    // Histogram model state.
    logic [ghn_pkg::COUNT_BITS_DEF-1:0] hist_bins [ghn_pkg::NUM_BINS_DEF];
    logic [ghn_pkg::COUNT_BITS_DEF-1:0] hist_peak;
    logic [ghn_pkg::SCALE_BITS-1:0]     scale_setting;
    t_read_result                       expected_reads [$];
    int                                 error_count = 0;

    gray_histogram_normalizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Model helpers.
    function automatic void histogram_clear();
        for (int b = 0; b < ghn_pkg::NUM_BINS_DEF; b++) begin
            hist_bins[b] = '0;
        end
        hist_peak = '0;
    endfunction

    // Applies one accepted item to the model and queues the result of a read.
    function automatic void histogram_apply(logic [ghn_pkg::MODE_BITS-1:0] mode,
                                            logic [ghn_pkg::PIXEL_BITS-1:0] pix,
                                            logic [ghn_pkg::PIXEL_BITS-1:0] idx);
        t_read_result                       res;
        logic [ghn_pkg::COUNT_BITS_DEF-1:0] cnt;
        longint unsigned                    product;
        unique case (mode)
            ghn_pkg::MODE_ADD: begin
                if (int'(pix) < ghn_pkg::NUM_BINS_DEF) begin
                    if (hist_bins[pix] != '1) begin
                        hist_bins[pix] = hist_bins[pix] + 1'b1;
                    end
                    if (hist_bins[pix] > hist_peak) begin
                        hist_peak = hist_bins[pix];
                    end
                end
            end
            ghn_pkg::MODE_READ: begin
                cnt = (int'(idx) < ghn_pkg::NUM_BINS_DEF) ? hist_bins[idx] : '0;
                product = longint'(cnt) * longint'(scale_setting);
                res.bin_count  = cnt[ghn_pkg::OUT_CNT_BITS-1:0];
                res.bar_height = (hist_peak == '0) ? '0 :
                                 16'(product / longint'(hist_peak));
                res.max_count  = hist_peak[ghn_pkg::OUT_CNT_BITS-1:0];
                expected_reads.push_back(res);
            end
            ghn_pkg::MODE_CLEAR: begin
                histogram_clear();
            end
            default: begin
            end
        endcase
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // Offers one item and waits until the block accepts it.
    task automatic send_item(logic [ghn_pkg::MODE_BITS-1:0] mode,
                             logic [ghn_pkg::PIXEL_BITS-1:0] pix,
                             logic [ghn_pkg::PIXEL_BITS-1:0] idx);
        int gap;
        gap = (tx_pace == PACE_BURSTY) ? idle_length() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = mode;
        s_axis_tdata  = {idx, pix};
        s_axis_tvalid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        histogram_apply(mode, pix, idx);
    endtask

    // Stops offering items and waits for every outstanding read result.
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_reads.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes bar_scale once the block is idle, clearing pass included.
    task automatic write_bar_scale(logic [ghn_pkg::SCALE_BITS-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        scale_setting = value;
    endtask

    // Reads on an empty histogram, bin edges, repeated bins, clear and mode 3.
    task automatic test_directed_items();
        tx_pace = PACE_STEADY;
        rx_pace = PACE_STEADY;
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h00);
        send_item(MODE_UNUSED, 8'hFF, 8'hFF);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'hFF);
        send_item(ghn_pkg::MODE_ADD, 8'h00, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'hFF, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'hFF, 8'hFF);
        send_item(ghn_pkg::MODE_ADD, 8'hFF, 8'h00);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'hFF);
        send_item(ghn_pkg::MODE_READ, 8'hFF, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'h80, 8'hFF);
        send_item(ghn_pkg::MODE_READ, 8'hFF, 8'h80);
        send_item(ghn_pkg::MODE_CLEAR, 8'hFF, 8'hFF);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'hFF);
        send_item(ghn_pkg::MODE_ADD, 8'hFF, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'h00, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'hFF, 8'h00);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'hFF);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h00);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h07);
        send_item(MODE_UNUSED, 8'h00, 8'h00);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h00);
    endtask

    // Zero, the smallest nonzero and the largest scale against the same counts.
    task automatic test_scale_extremes();
        write_bar_scale('0);
        send_item(ghn_pkg::MODE_ADD, 8'h09, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'h09, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'h09, 8'h00);
        send_item(ghn_pkg::MODE_ADD, 8'h0A, 8'h00);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h09);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h0A);
        write_bar_scale(16'd1);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h09);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h0A);
        write_bar_scale(16'hFFFF);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h09);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'h0A);
        send_item(ghn_pkg::MODE_READ, 8'h00, 8'hFF);
    endtask

    // The receiver holds off for a long stretch while reads keep coming.
    task automatic test_backpressure();
        tx_pace = PACE_STEADY;
        rx_hold_ticket++;
        for (int n = 0; n < 40; n++) begin
            if (n % 3 == 2) begin
                send_item(ghn_pkg::MODE_READ, 8'($urandom), 8'(n % 5));
            end else begin
                send_item(ghn_pkg::MODE_ADD, 8'(n % 5), 8'($urandom));
            end
        end
    endtask

    // The sender stops until all results are in, then resumes.
    task automatic test_drain_pause();
        tx_pace = PACE_BURSTY;
        rx_pace = PACE_BURSTY;
        for (int n = 0; n < 20; n++) begin
            if (n == 10) begin
                wait_results_drained();
            end
            send_item((n % 2 == 0) ? ghn_pkg::MODE_ADD : ghn_pkg::MODE_READ,
                      8'(n), 8'(n - 1));
        end
    endtask

    // Bursts of adds around a hot bin, reads of hot and random bins,
    // occasional clears and ignored items.
    task automatic test_random_traffic(int phase, int items);
        int                             sent;
        int                             r;
        int                             len;
        logic [ghn_pkg::PIXEL_BITS-1:0] hot;
        logic [ghn_pkg::PIXEL_BITS-1:0] pick;
        case (phase)
            0: write_bar_scale(16'hFFFF);
            1: write_bar_scale(16'd1);
            2: write_bar_scale(16'($urandom_range(1, 65535)));
            default: write_bar_scale(ghn_pkg::BAR_SCALE_RESET);
        endcase
        tx_pace = (phase % 2 == 1) ? PACE_BURSTY : PACE_STEADY;
        rx_pace = (phase == 0 || phase == 3) ? PACE_STEADY : PACE_BURSTY;
        if (phase == 0) begin
            rx_pace = PACE_BURSTY;
        end
        sent = 0;
        hot  = 8'($urandom);
        while (sent < items) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = $urandom_range(1, 24);
                hot = 8'($urandom);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 1) ? hot : 8'($urandom);
                    send_item(ghn_pkg::MODE_ADD, pick, 8'($urandom));
                    sent++;
                end
            end else if (r < 92) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 1) ? hot : 8'($urandom);
                    send_item(ghn_pkg::MODE_READ, 8'($urandom), pick);
                    sent++;
                end
            end else if (r < 95) begin
                send_item(ghn_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom));
                sent++;
            end else begin
                send_item(MODE_UNUSED, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        int stall_left;
        int hold_left;
        int tickets_seen;
        stall_left   = 0;
        hold_left    = 0;
        tickets_seen = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_ticket != tickets_seen) begin
                tickets_seen = rx_hold_ticket;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (rx_pace == PACE_STEADY) begin
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else begin
                stall_left    = idle_length();
                m_axis_tready = (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // Compare each result transaction with the oldest expected read.
    always @(posedge i_clk) begin
        t_read_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reads.size() == 0) begin
                $error("result with no read outstanding: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_reads.pop_front();
                if (m_axis_tdata[23:0] !== want.bin_count) begin
                    $error("bin_count: expected %0d, actual %0d",
                           want.bin_count, m_axis_tdata[23:0]);
                    error_count++;
                end
                if (m_axis_tdata[39:24] !== want.bar_height) begin
                    $error("bar_height: expected %0d, actual %0d",
                           want.bar_height, m_axis_tdata[39:24]);
                    error_count++;
                end
                if (m_axis_tdata[63:40] !== want.max_count) begin
                    $error("max_count: expected %0d, actual %0d",
                           want.max_count, m_axis_tdata[63:40]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // Test sequence.
    initial begin
        histogram_clear();
        scale_setting = ghn_pkg::BAR_SCALE_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_items();
        test_scale_extremes();
        test_backpressure();
        for (int phase = 0; phase < 4; phase++) begin
            test_random_traffic(phase, RANDOM_ITEMS / 4);
        end
        test_drain_pause();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
